@@ rtl/pm_pkg.sv @@
// ----------------------------------------------------------------------------
// pm_pkg: shared types and constants for the polynomial multiplier.
// Holds coefficient widths, the default term and lane counts, the product
// and accumulator widths and the control state type.
// ----------------------------------------------------------------------------
package pm_pkg;

  localparam int COEFF_W       = 32;
  localparam int INDEX_W       = 5;
  localparam int MAX_TERMS_DEF = 16;
  localparam int NUM_LANES_DEF = 4;
  // Exact Q32.32 product width and a generous accumulator width.
  localparam int PROD_W        = 64;
  localparam int ACC_W         = 72;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CALC,
    ST_DRAIN,
    ST_OUT
  } pm_state_t;

endpackage

@@ rtl/polynomial_multiply.sv @@
// ----------------------------------------------------------------------------
// polynomial_multiply: streaming product of two polynomials in Q16.16.
//
// Input beat k carries coefficient k of each operand; it is stored and the
// block returns product coefficient k. On a beat with last high, or on beat
// MAX_TERMS-1 of a run, it also returns coefficients k+1 .. 2k and flags the
// final one with out_last_term, then starts a new run.
// Each result term is formed by NUM_LANES multiply-accumulate lanes that
// walk the stored pairs, lane l taking pairs l, l+NUM_LANES, ...; a merge
// stage adds the lane sums, truncates toward zero and saturates.
// An input beat is taken only when all of the previous beat's results have
// been delivered.
// Results wait in an output register; while the receiver stalls, the block
// holds the result and takes no new work. Reset clears the run count and
// control state; stored coefficients are written before they are read.
// ----------------------------------------------------------------------------
module polynomial_multiply #(
  parameter int MAX_TERMS = pm_pkg::MAX_TERMS_DEF,
  parameter int NUM_LANES = pm_pkg::NUM_LANES_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic signed [pm_pkg::COEFF_W-1:0] in_p_coeff,
  input  logic signed [pm_pkg::COEFF_W-1:0] in_q_coeff,
  input  logic                              in_last,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [pm_pkg::COEFF_W-1:0] out_product_coeff,
  output logic        [pm_pkg::INDEX_W-1:0] out_term_index,
  output logic                              out_last_term,
  output logic                              out_overflow
);
  import pm_pkg::*;

  localparam int IDX_W  = $clog2(MAX_TERMS);
  localparam int KW     = IDX_W + 2;
  localparam int STEPS  = (MAX_TERMS + NUM_LANES - 1) / NUM_LANES;
  localparam int STEP_W = $clog2(STEPS + 1);

  logic signed [COEFF_W-1:0] p_mem [MAX_TERMS];
  logic signed [COEFF_W-1:0] q_mem [MAX_TERMS];

  pm_state_t          state_r, state_nxt;
  logic [IDX_W-1:0]   count_r;      // index of next input beat
  logic [IDX_W-1:0]   top_r;        // highest stored index of this beat
  logic [KW-1:0]      k_r;          // term being computed
  logic [KW-1:0]      k_end_r;      // last term for this beat
  logic               fin_r;
  logic [STEP_W-1:0]  step_r;
  logic [1:0]         drain_r;

  logic               in_fire;
  logic               out_fire;
  logic [IDX_W-1:0]   k_in;
  logic               fin_in;

  logic signed [NUM_LANES-1:0][ACC_W-1:0] lane_sum;
  logic [NUM_LANES-1:0]                   lane_en;
  logic signed [COEFF_W-1:0]              lane_a [NUM_LANES];
  logic signed [COEFF_W-1:0]              lane_b [NUM_LANES];
  logic                                   lane_clr;
  logic [COEFF_W-1:0]                     m_coeff;
  logic                                   m_ovf;
  logic                                   m_load;

  assign in_ready = (state_r == ST_IDLE);
  assign in_fire  = in_valid && in_ready;
  assign out_fire = out_valid && out_ready;
  assign k_in     = count_r;
  assign fin_in   = in_last || (count_r == IDX_W'(MAX_TERMS - 1));

  // Coefficient stores.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      p_mem[k_in] <= in_p_coeff;
      q_mem[k_in] <= in_q_coeff;
    end
  end

  // Lane operand selection: lane l takes i = l + NUM_LANES*step.
  always_comb begin
    for (int l = 0; l < NUM_LANES; l++) begin
      logic [KW+STEP_W:0] i_w;
      logic [KW+STEP_W:0] j_w;
      i_w = (KW+STEP_W+1)'(l) + (KW+STEP_W+1)'(step_r) * (KW+STEP_W+1)'(NUM_LANES);
      j_w = (KW+STEP_W+1)'(k_r) - i_w;
      lane_en[l] = (state_r == ST_CALC) && (i_w <= (KW+STEP_W+1)'(top_r))
                   && (i_w <= (KW+STEP_W+1)'(k_r))
                   && (j_w <= (KW+STEP_W+1)'(top_r));
      lane_a[l] = p_mem[i_w[IDX_W-1:0]];
      lane_b[l] = q_mem[j_w[IDX_W-1:0]];
      if (!lane_en[l]) begin
        lane_a[l] = '0;
        lane_b[l] = '0;
      end
    end
  end

  assign lane_clr = in_fire || out_fire;

  for (genvar g = 0; g < NUM_LANES; g++) begin : g_lane
    pm_lane u_lane (
      .clk   (clk),
      .clear (lane_clr),
      .en    (lane_en[g]),
      .a     (lane_a[g]),
      .b     (lane_b[g]),
      .sum   (lane_sum[g])
    );
  end

  assign m_load = (state_r == ST_DRAIN) && (drain_r == 2'd1);

  pm_merge #(.NUM_LANES(NUM_LANES)) u_merge (
    .clk   (clk),
    .load  (m_load),
    .sums  (lane_sum),
    .coeff (m_coeff),
    .ovf   (m_ovf)
  );

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      count_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (in_fire) begin
        count_r <= fin_in ? '0 : count_r + IDX_W'(1);
      end
    end
  end

  // Per-beat and per-term counters.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      top_r   <= k_in;
      k_r     <= KW'(k_in);
      k_end_r <= fin_in ? KW'({k_in, 1'b0}) : KW'(k_in);
      fin_r   <= fin_in;
      step_r  <= '0;
      drain_r <= '0;
    end else if (state_r == ST_CALC) begin
      step_r <= step_r + STEP_W'(1);
    end else if (state_r == ST_DRAIN) begin
      drain_r <= drain_r + 2'd1;
    end else if (out_fire) begin
      k_r     <= k_r + KW'(1);
      step_r  <= '0;
      drain_r <= '0;
    end
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:  if (in_fire) state_nxt = ST_CALC;
      ST_CALC:  if (step_r == STEP_W'(STEPS - 1)) state_nxt = ST_DRAIN;
      ST_DRAIN: if (drain_r == 2'd2) state_nxt = ST_OUT;
      ST_OUT: begin
        if (out_fire) begin
          state_nxt = (k_r == k_end_r) ? ST_IDLE : ST_CALC;
        end
      end
      default:  state_nxt = ST_IDLE;
    endcase
  end

  assign out_valid         = (state_r == ST_OUT);
  assign out_product_coeff = m_coeff;
  assign out_term_index    = INDEX_W'(k_r);
  assign out_last_term     = fin_r && (k_r == k_end_r);
  assign out_overflow      = m_ovf;

  // Checks.
  a_no_in_while_busy : assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_IDLE) |-> !in_ready)
    else $error("input taken while busy");
  a_out_hold : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_term_index)))
    else $error("result dropped under stall");
  a_term_range : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (k_r <= k_end_r))
    else $error("term index beyond run end");

endmodule

@@ rtl/pm_lane.sv @@
// ----------------------------------------------------------------------------
// pm_lane: one multiply-accumulate lane.
// Multiplies one stored coefficient pair per cycle, registers the product,
// then adds it to a running sum that is cleared at the start of each term.
// ----------------------------------------------------------------------------
module pm_lane (
  input  logic                                 clk,
  input  logic                                 clear,
  input  logic                                 en,
  input  logic signed [pm_pkg::COEFF_W-1:0]    a,
  input  logic signed [pm_pkg::COEFF_W-1:0]    b,
  output logic signed [pm_pkg::ACC_W-1:0]      sum
);
  import pm_pkg::*;

  logic signed [PROD_W-1:0] prod_r;
  logic                     prod_vld_r;
  logic signed [ACC_W-1:0]  sum_r;

  // Product register, then accumulate.
  always_ff @(posedge clk) begin
    prod_r     <= a * b;
    prod_vld_r <= en;
    if (clear) begin
      sum_r      <= '0;
      prod_vld_r <= 1'b0;
    end else if (prod_vld_r) begin
      sum_r <= sum_r + ACC_W'(prod_r);
    end
  end

  assign sum = sum_r;

endmodule

@@ rtl/pm_merge.sv @@
// ----------------------------------------------------------------------------
// pm_merge: combines the lane sums into one product coefficient.
// Adds the lane sums in a register, then truncates toward zero to Q16.16
// and saturates to 32 bits.
// ----------------------------------------------------------------------------
module pm_merge #(
  parameter int NUM_LANES = pm_pkg::NUM_LANES_DEF
) (
  input  logic                                              clk,
  input  logic                                              load,
  input  logic signed [NUM_LANES-1:0][pm_pkg::ACC_W-1:0]    sums,
  output logic        [pm_pkg::COEFF_W-1:0]                 coeff,
  output logic                                              ovf
);
  import pm_pkg::*;

  logic signed [ACC_W-1:0] total_r;
  logic signed [ACC_W-1:0] total_nxt;
  logic signed [ACC_W-1:0] trunc;

  always_comb begin
    total_nxt = '0;
    for (int l = 0; l < NUM_LANES; l++) begin
      total_nxt = total_nxt + sums[l];
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      total_r <= total_nxt;
    end
  end

  // Round toward zero: negative values with fraction bits move up by one.
  always_comb begin
    trunc = total_r >>> 16;
    if (total_r[ACC_W-1] && (total_r[15:0] != '0)) begin
      trunc = trunc + ACC_W'(1);
    end
    ovf   = 1'b0;
    coeff = trunc[COEFF_W-1:0];
    if (trunc > ACC_W'(signed'(33'sh0_7FFF_FFFF))) begin
      coeff = 32'h7FFF_FFFF;
      ovf   = 1'b1;
    end else if (trunc < -(ACC_W'(signed'(33'sh0_8000_0000)))) begin
      coeff = 32'h8000_0000;
      ovf   = 1'b1;
    end
  end

endmodule

@@ sim/testbench.sv @@
// ----------------------------------------------------------------------------
// Polynomial multiplier testbench
// Streams coefficient pairs into the block, predicts every product
// coefficient by exact convolution with truncation and saturation, and
// checks each result beat in order under several idling patterns.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;

  localparam int NTERMS    = pm_pkg::MAX_TERMS_DEF;
  localparam int CYC_LIMIT = 400000;

  typedef struct packed {
    logic signed [31:0] coeff;
    logic [4:0]         index;
    logic               last_term;
    logic               ovf;
  } product_beat_t;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  logic signed [31:0] in_p_coeff;
  logic signed [31:0] in_q_coeff;
  logic in_last;
  logic out_valid;
  logic out_ready;
  logic signed [31:0] out_product_coeff;
  logic [4:0] out_term_index;
  logic out_last_term;
  logic out_overflow;

  polynomial_multiply u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_p_coeff(in_p_coeff), .in_q_coeff(in_q_coeff), .in_last(in_last),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_product_coeff(out_product_coeff), .out_term_index(out_term_index),
    .out_last_term(out_last_term), .out_overflow(out_overflow)
  );

  // Predictor state: coefficients of the run in progress.
  logic signed [31:0] p_terms [NTERMS];
  logic signed [31:0] q_terms [NTERMS];
  int unsigned run_len;
  product_beat_t pending_products [$];

  int  send_idle_pct;
  int  recv_stall_pct;
  int  mismatches;
  int  cycles;
  bit  failed;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Exact convolution term k over stored pairs 0..top.
  function automatic product_beat_t conv_term(int unsigned k, int unsigned top, bit fin);
    product_beat_t r;
    logic signed [71:0] acc;
    logic signed [71:0] q;
    int lo_i;
    acc = '0;
    lo_i = (k > top) ? k - top : 0;
    for (int i = lo_i; i <= top && i <= k; i++)
      acc += 72'(signed'(p_terms[i])) * 72'(signed'(q_terms[k - i]));
    // Arithmetic shift floors; bump up for negative with a remainder.
    q = acc >>> 16;
    if (acc < 0 && acc[15:0] != 16'd0) q = q + 1;
    r.index = k[4:0];
    r.last_term = fin;
    if (q > 72'sh7FFFFFFF) begin
      r.coeff = 32'h7FFFFFFF;
      r.ovf = 1'b1;
    end else if (q < -72'sh80000000) begin
      r.coeff = 32'h80000000;
      r.ovf = 1'b1;
    end else begin
      r.coeff = q[31:0];
      r.ovf = 1'b0;
    end
    return r;
  endfunction

  // Store one accepted pair and queue the product coefficients it releases.
  task automatic predict_products(logic signed [31:0] p, logic signed [31:0] q, logic lst);
    int unsigned k;
    bit fin;
    k = run_len;
    p_terms[k] = p;
    q_terms[k] = q;
    fin = lst || (k == NTERMS - 1);
    pending_products.push_back(conv_term(k, k, fin && k == 0));
    if (fin) begin
      for (int unsigned m = k + 1; m <= 2 * k; m++)
        pending_products.push_back(conv_term(m, k, m == 2 * k));
      run_len = 0;
    end else begin
      run_len = k + 1;
    end
  endtask

  // Send one beat, with optional random idle cycles first. Valid stays high
  // after acceptance until the next beat or an idle cycle replaces it.
  task automatic send_pair(logic signed [31:0] p, logic signed [31:0] q, logic lst);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_p_coeff <= p;
    in_q_coeff <= q;
    in_last <= lst;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_products(p, q, lst);
  endtask

  // Receiver stall pattern.
  always @(posedge clk) begin
    if (rst_n) out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Check each result beat against the oldest expectation.
  always @(posedge clk) begin
    product_beat_t exp_b;
    if (rst_n && out_valid && out_ready) begin
      if (pending_products.size() == 0) begin
        failed = 1'b1;
        mismatches++;
        if (mismatches <= 10)
          $display("Unexpected result beat: index %0d coeff %h", out_term_index,
                   out_product_coeff);
      end else begin
        exp_b = pending_products.pop_front();
        if (exp_b.coeff !== out_product_coeff || exp_b.index !== out_term_index ||
            exp_b.last_term !== out_last_term || exp_b.ovf !== out_overflow) begin
          failed = 1'b1;
          mismatches++;
          if (mismatches <= 10)
            $display("Mismatch: exp coeff %h idx %0d last %b ovf %b, got %h %0d %b %b",
                     exp_b.coeff, exp_b.index, exp_b.last_term, exp_b.ovf,
                     out_product_coeff, out_term_index, out_last_term, out_overflow);
        end
      end
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYC_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  function automatic logic signed [31:0] rand_coeff();
    case ($urandom_range(5))
      0: return 32'h7FFFFFFF;
      1: return 32'h80000000;
      2: return 32'($urandom_range(1 << 18)) - 32'sd131072;
      default: return $urandom;
    endcase
  endfunction

  // Drop valid and wait until every queued result has been checked.
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_products.size() != 0) @(posedge clk);
  endtask

  // Extremes, saturation both ways, single-item runs and the forced last.
  task automatic test_directed();
    send_pair(32'h00010000, 32'h00010000, 1'b1);
    send_pair(32'h7FFFFFFF, 32'h7FFFFFFF, 1'b1);
    send_pair(32'h80000000, 32'h80000000, 1'b1);
    send_pair(32'h80000000, 32'h7FFFFFFF, 1'b1);
    send_pair(32'hFFFFFFFF, 32'h00000001, 1'b1);
    send_pair(32'h00000000, 32'h00000000, 1'b1);
    send_pair(32'h00018000, 32'hFFFF0000, 1'b0);
    send_pair(32'h7FFFFFFF, 32'h80000000, 1'b0);
    send_pair(32'h12345678, 32'hEDCBA987, 1'b1);
    for (int i = 0; i < NTERMS; i++)
      send_pair(i[0] ? 32'h80000000 : 32'h7FFFFFFF, 32'h7FFFFFFF, 1'b0);
  endtask

  // Random runs of mostly short length, a few at full length.
  task automatic test_random(int n_items);
    int len;
    int sent;
    sent = 0;
    while (sent < n_items) begin
      len = ($urandom_range(9) == 0) ? NTERMS : $urandom_range(1, 6);
      for (int i = 0; i < len; i++) begin
        send_pair(rand_coeff(), rand_coeff(), i == len - 1 && $urandom_range(7) != 0);
        sent++;
      end
    end
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_p_coeff = '0;
    in_q_coeff = '0;
    in_last = 1'b0;
    out_ready = 1'b0;
    run_len = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    mismatches = 0;
    cycles = 0;
    failed = 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_random(30);
    // Hold off until every pending result is out.
    wait_drained();
    send_idle_pct = 54;
    test_random(30);
    send_idle_pct = 0;
    recv_stall_pct = 54;
    test_random(30);
    send_idle_pct = 36;
    recv_stall_pct = 36;
    test_random(30);
    // Close any open run so its products come out.
    send_pair(rand_coeff(), rand_coeff(), 1'b1);

    wait_drained();
    repeat (50) @(posedge clk);
    if (!failed) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
